[design/ctlr_pkg.sv]
// ----------------------------------------------------------------------------
// ctlr_pkg: shared types, codes and lookup tables of the telemetry linearizer
// Holds the selector codes, the two breakpoint tables and the command and
// status bundles exchanged between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ctlr_pkg;

  localparam logic [7:0] SEL_SPEED = 8'h30;
  localparam logic [7:0] SEL_CTRL  = 8'h4a;
  localparam logic [7:0] SEL_MOTOR = 8'h49;

  localparam int unsigned MOTOR_PTS = 39;
  localparam int unsigned CTRL_PTS  = 32;
  localparam int unsigned IDX_W     = 6;

  localparam logic [IDX_W-1:0] MOTOR_LAST = IDX_W'(MOTOR_PTS - 1);
  localparam logic [IDX_W-1:0] CTRL_LAST  = IDX_W'(CTRL_PTS - 1);

  localparam int unsigned DEG_W = 11;
  localparam int unsigned ACC_W = 24;
  localparam int unsigned NUM_W = 20;
  localparam int unsigned DEN_W = 17;
  localparam int unsigned CNT_W = 5;
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(NUM_W - 1);

  typedef enum logic [2:0] {
    KIND_OTHER,
    KIND_SPEED,
    KIND_MOTOR,
    KIND_CTRL,
    KIND_TICK
  } kind_e;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic store_speed;
    logic search_step;
    logic store_clamp;
    logic mul1;
    logic mul2;
    logic div_init;
    logic div_step;
    logic store_deg;
    logic report;
  } ctlr_cmd_t;

  // datapath -> controller
  typedef struct packed {
    kind_e kind;
    logic  hit;
    logic  last;
    logic  div_last;
    logic  out_free;
  } ctlr_sts_t;

  function automatic logic [15:0] motor_raw(input logic [IDX_W-1:0] idx);
    logic [15:0] v;
    unique case (idx)
      6'd0:  v = 16'd7414;  6'd1:  v = 16'd7687;  6'd2:  v = 16'd7962;
      6'd3:  v = 16'd8240;  6'd4:  v = 16'd8520;  6'd5:  v = 16'd8802;
      6'd6:  v = 16'd9085;  6'd7:  v = 16'd9369;  6'd8:  v = 16'd9654;
      6'd9:  v = 16'd9939;  6'd10: v = 16'd10225; 6'd11: v = 16'd10510;
      6'd12: v = 16'd10795; 6'd13: v = 16'd11080; 6'd14: v = 16'd11364;
      6'd15: v = 16'd11646; 6'd16: v = 16'd11927; 6'd17: v = 16'd12207;
      6'd18: v = 16'd12485; 6'd19: v = 16'd12762; 6'd20: v = 16'd13036;
      6'd21: v = 16'd13308; 6'd22: v = 16'd13578; 6'd23: v = 16'd13846;
      6'd24: v = 16'd14111; 6'd25: v = 16'd14373; 6'd26: v = 16'd14633;
      6'd27: v = 16'd14890; 6'd28: v = 16'd15144; 6'd29: v = 16'd15391;
      6'd30: v = 16'd15632; 6'd31: v = 16'd15852; 6'd32: v = 16'd16061;
      6'd33: v = 16'd16251; 6'd34: v = 16'd16421; 6'd35: v = 16'd16569;
      6'd36: v = 16'd16692; 6'd37: v = 16'd16789; 6'd38: v = 16'd16857;
      default: v = 16'd16857;
    endcase
    return v;
  endfunction

  function automatic logic [15:0] ctrl_raw(input logic [IDX_W-1:0] idx);
    logic [15:0] v;
    unique case (idx)
      6'd0:  v = 16'd28480; 6'd1:  v = 16'd28179; 6'd2:  v = 16'd27851;
      6'd3:  v = 16'd27497; 6'd4:  v = 16'd27114; 6'd5:  v = 16'd26702;
      6'd6:  v = 16'd26261; 6'd7:  v = 16'd25792; 6'd8:  v = 16'd25296;
      6'd9:  v = 16'd24775; 6'd10: v = 16'd24232; 6'd11: v = 16'd23671;
      6'd12: v = 16'd23097; 6'd13: v = 16'd22515; 6'd14: v = 16'd21933;
      6'd15: v = 16'd21357; 6'd16: v = 16'd20793; 6'd17: v = 16'd20250;
      6'd18: v = 16'd19733; 6'd19: v = 16'd19247; 6'd20: v = 16'd18797;
      6'd21: v = 16'd18387; 6'd22: v = 16'd18017; 6'd23: v = 16'd17688;
      6'd24: v = 16'd17400; 6'd25: v = 16'd17151; 6'd26: v = 16'd16938;
      6'd27: v = 16'd16757; 6'd28: v = 16'd16609; 6'd29: v = 16'd16487;
      6'd30: v = 16'd16387; 6'd31: v = 16'd16308;
      default: v = 16'd16308;
    endcase
    return v;
  endfunction

  // Breakpoints sit on a 5 degree grid: motor from -35 up, controller from 125 down.
  function automatic logic signed [DEG_W-1:0] motor_deg(input logic [IDX_W-1:0] idx);
    return $signed({5'b0, idx}) * 11'sd5 - 11'sd35;
  endfunction

  function automatic logic signed [DEG_W-1:0] ctrl_deg(input logic [IDX_W-1:0] idx);
    return 11'sd125 - $signed({5'b0, idx}) * 11'sd5;
  endfunction

endpackage

`default_nettype wire

[design/ctlr_datapath.sv]
// ----------------------------------------------------------------------------
// ctlr_datapath: storage and arithmetic of the telemetry linearizer
// Latches the input word, walks the breakpoint table, forms the segment
// numerator with two multiplies, divides bit-serially and holds the report.
// ----------------------------------------------------------------------------
`default_nettype none

module ctlr_datapath
  import ctlr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [15:0] s_axis_tdata,   // low_byte, high_byte
  input  wire logic [8:0]  s_axis_tuser,   // command, reg_code
  input  wire logic [7:0]  battery_i,
  input  wire logic        m_axis_tready,
  input  wire ctlr_cmd_t   cmd_i,
  output ctlr_sts_t        sts_o,
  output logic             m_axis_tvalid,
  output logic [31:0]      m_axis_tdata    // speed, motor temp, battery, ctrl temp
);

  // payload
  logic [15:0]                word_q;
  kind_e                      kind_q;
  logic [IDX_W-1:0]           idx_q;
  logic signed [ACC_W-1:0]    acc_q, acc_d;
  logic signed [DEN_W-1:0]    den_q, den_d;
  logic [DEN_W-1:0]           rem_q, rem_d;
  logic [NUM_W-1:0]           quo_q, quo_d;
  logic                       neg_q, neg_d;
  logic [CNT_W-1:0]           cnt_q;
  logic [31:0]                out_q;

  // architectural state
  logic [15:0]                speed_now_q, speed_sent_q;
  logic [DEG_W-1:0]           motor_now_q, motor_sent_q;
  logic [DEG_W-1:0]           ctrl_now_q, ctrl_sent_q;
  logic [7:0]                 battery_sent_q;
  logic                       first_q;
  logic                       out_valid_q;

  kind_e                      kind_in;
  logic                       is_motor;
  logic [IDX_W-1:0]           idx_prev;
  logic [15:0]                raw_cur, raw_prev;
  logic signed [DEG_W-1:0]    deg_cur, deg_prev, deg_clamp, deg_step;
  logic signed [DEN_W-1:0]    seg_den, seg_off;
  logic signed [ACC_W-1:0]    num_fix;
  logic [DEN_W-1:0]           rem_sh;
  logic                       rem_ge;
  logic [DEG_W-1:0]           deg_res;
  logic                       changed;

  always_comb begin
    if (s_axis_tuser[0]) begin
      kind_in = KIND_TICK;
    end else begin
      unique case (s_axis_tuser[8:1])
        SEL_SPEED: kind_in = KIND_SPEED;
        SEL_MOTOR: kind_in = KIND_MOTOR;
        SEL_CTRL:  kind_in = KIND_CTRL;
        default:   kind_in = KIND_OTHER;
      endcase
    end
  end

  assign is_motor  = (kind_q == KIND_MOTOR);
  assign idx_prev  = idx_q - IDX_W'(1);
  assign raw_cur   = is_motor ? motor_raw(idx_q)    : ctrl_raw(idx_q);
  assign raw_prev  = is_motor ? motor_raw(idx_prev) : ctrl_raw(idx_prev);
  assign deg_cur   = is_motor ? motor_deg(idx_q)    : ctrl_deg(idx_q);
  assign deg_prev  = is_motor ? motor_deg(idx_prev) : ctrl_deg(idx_prev);
  assign deg_clamp = is_motor ? motor_deg(MOTOR_LAST) : ctrl_deg(CTRL_LAST);
  assign deg_step  = deg_cur - deg_prev;
  assign seg_den   = $signed({1'b0, raw_cur}) - $signed({1'b0, raw_prev});
  assign seg_off   = $signed({1'b0, word_q}) - $signed({1'b0, raw_prev});

  // Flip signs so the divisor is positive; the quotient keeps the numerator sign.
  assign num_fix = den_q[DEN_W-1] ? -acc_q : acc_q;

  assign rem_sh  = {rem_q[DEN_W-2:0], quo_q[NUM_W-1]};
  assign rem_ge  = (rem_sh >= den_q);
  assign deg_res = neg_q ? DEG_W'(-quo_q) : DEG_W'(quo_q);

  assign changed = first_q || (speed_now_q != speed_sent_q) ||
                   (motor_now_q != motor_sent_q) || (ctrl_now_q != ctrl_sent_q) ||
                   (battery_i != battery_sent_q);

  always_comb begin
    acc_d = acc_q;
    den_d = den_q;
    rem_d = rem_q;
    quo_d = quo_q;
    neg_d = neg_q;
    priority if (cmd_i.mul1) begin
      acc_d = ACC_W'(deg_prev) * ACC_W'(seg_den);
      den_d = seg_den;
    end else if (cmd_i.mul2) begin
      acc_d = acc_q + ACC_W'(seg_off) * ACC_W'(deg_step);
    end else if (cmd_i.div_init) begin
      neg_d = num_fix[ACC_W-1];
      quo_d = num_fix[ACC_W-1] ? NUM_W'(-num_fix) : NUM_W'(num_fix);
      rem_d = '0;
      den_d = den_q[DEN_W-1] ? -den_q : den_q;
    end else if (cmd_i.div_step) begin
      rem_d = rem_ge ? rem_sh - den_q : rem_sh;
      quo_d = {quo_q[NUM_W-2:0], rem_ge};
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    den_q <= den_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    neg_q <= neg_d;
    if (cmd_i.load) begin
      word_q <= s_axis_tdata;
      kind_q <= kind_in;
      idx_q  <= IDX_W'(1);
    end else if (cmd_i.search_step) begin
      idx_q <= idx_q + IDX_W'(1);
    end
    if (cmd_i.div_init) begin
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q + CNT_W'(1);
    end
    if (cmd_i.report && changed) begin
      out_q <= {ctrl_now_q[7:0], battery_i, motor_now_q[7:0], speed_now_q[7:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_now_q    <= '0;
      motor_now_q    <= '0;
      ctrl_now_q     <= '0;
      speed_sent_q   <= '0;
      motor_sent_q   <= '0;
      ctrl_sent_q    <= '0;
      battery_sent_q <= '0;
      first_q        <= 1'b1;
      out_valid_q    <= 1'b0;
    end else begin
      if (cmd_i.store_speed) begin
        speed_now_q <= word_q;
      end
      if (cmd_i.store_clamp || cmd_i.store_deg) begin
        if (is_motor) begin
          motor_now_q <= cmd_i.store_clamp ? deg_clamp : deg_res;
        end else begin
          ctrl_now_q <= cmd_i.store_clamp ? deg_clamp : deg_res;
        end
      end
      if (cmd_i.report && changed) begin
        speed_sent_q   <= speed_now_q;
        motor_sent_q   <= motor_now_q;
        ctrl_sent_q    <= ctrl_now_q;
        battery_sent_q <= battery_i;
        first_q        <= 1'b0;
        out_valid_q    <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.kind     = kind_q;
  assign sts_o.hit      = is_motor ? (word_q <= raw_cur) : (word_q >= raw_cur);
  assign sts_o.last     = is_motor ? (idx_q == MOTOR_LAST) : (idx_q == CTRL_LAST);
  assign sts_o.div_last = (cnt_q == DIV_LAST);
  assign sts_o.out_free = !out_valid_q || m_axis_tready;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule

`default_nettype wire

[design/ctlr_ctrl.sv]
// ----------------------------------------------------------------------------
// ctlr_ctrl: sequencer of the telemetry linearizer
// Accepts one word at a time and steps the datapath through table search,
// numerator build, division and store, or through a speed store or a report decision.
// ----------------------------------------------------------------------------
`default_nettype none

module ctlr_ctrl
  import ctlr_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      s_axis_tvalid,
  output logic           s_axis_tready,
  input  wire ctlr_sts_t sts_i,
  output ctlr_cmd_t      cmd_o
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_DECODE = 4'd1;
  localparam logic [3:0] ST_SEARCH = 4'd2;
  localparam logic [3:0] ST_MUL1   = 4'd3;
  localparam logic [3:0] ST_MUL2   = 4'd4;
  localparam logic [3:0] ST_FIX    = 4'd5;
  localparam logic [3:0] ST_DIV    = 4'd6;
  localparam logic [3:0] ST_STORE  = 4'd7;
  localparam logic [3:0] ST_TICK   = 4'd8;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (sts_i.kind)
          KIND_SPEED: begin
            cmd_o.store_speed = 1'b1;
            state_d           = ST_IDLE;
          end
          KIND_MOTOR, KIND_CTRL: state_d = ST_SEARCH;
          KIND_TICK:             state_d = ST_TICK;
          default:               state_d = ST_IDLE;
        endcase
      end
      ST_SEARCH: begin
        priority if (sts_i.hit) begin
          state_d = ST_MUL1;
        end else if (sts_i.last) begin
          cmd_o.store_clamp = 1'b1;
          state_d           = ST_IDLE;
        end else begin
          cmd_o.search_step = 1'b1;
        end
      end
      ST_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = ST_MUL2;
      end
      ST_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = ST_FIX;
      end
      ST_FIX: begin
        cmd_o.div_init = 1'b1;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_STORE;
        end
      end
      ST_STORE: begin
        cmd_o.store_deg = 1'b1;
        state_d         = ST_IDLE;
      end
      ST_TICK: begin
        if (sts_i.out_free) begin
          cmd_o.report = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);

endmodule

`default_nettype wire

[design/can_telemetry_linearize_report.sv]
// ----------------------------------------------------------------------------
// can_telemetry_linearize_report: CAN telemetry linearizer and change reporter
// Stores speed and table-linearized motor and controller temperatures from
// telemetry frames; on a report tick emits one word if anything changed.
// ----------------------------------------------------------------------------
//
//  port group   dir   word contents (low bit first)
//  -----------  ----  ----------------------------------------------------
//  s_axis_*     in    tuser: command, reg_code; tdata: low_byte, high_byte
//  m_axis_*     out   tdata: speed, motor temp, battery, controller temp
//  APB          in    register 0 at byte 0: battery value (8 bits)
//
// One word is taken at a time. A temperature frame walks the breakpoint table one
// point per cycle (up to 38 for motor, 31 for controller), then runs two multiplies,
// a divider set-up, a bit-serial restoring divider with a 20-bit quotient and a store.
// A finished report sits in the output register; frames keep flowing while it
// waits, and only a following tick stalls until it is taken.
// Reset clears all stored quantities and forces the first tick to report.
//
`default_nettype none

module can_telemetry_linearize_report
  import ctlr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input words
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [7:0] low_byte, [15:8] high_byte
  input  wire logic [8:0]  s_axis_tuser,   // [0] command, [8:1] reg_code
  // report words
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [7:0] speed_out, [15:8] motor_temp_out,
                                           // [23:16] battery_out,
                                           // [31:24] controller_temp_out
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [7:0] battery_q;
  ctlr_cmd_t  cmd;
  ctlr_sts_t  sts;

  // Register file: a single battery level, decoded on the word address bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      battery_q <= '0;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      battery_q <= pwdata[7:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {24'd0, battery_q};

  ctlr_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  ctlr_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .battery_i     (battery_q),
    .m_axis_tready (m_axis_tready),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tdata  (m_axis_tdata)
  );

  // A report word only appears right after a report decision.
  a_valid_from_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(cmd.report))
    else $error("report word raised without a report decision");

  // Never decide a report while the output register still holds an untaken word.
  a_report_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.report |-> sts.out_free)
    else $error("report decided over a pending word");

  // An accepted frame never produces a word in the next cycle.
  a_frame_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && !s_axis_tuser[0] && !m_axis_tvalid)
      |=> !m_axis_tvalid)
    else $error("frame produced a report word");

endmodule

`default_nettype wire
